[hdl/assert_macros.svh]
// Assertion macros shared by the line convolution RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`endif
`endif

[hdl/lcz_pkg.sv]
// Shared types and constants of the line convolution block.
package lcz_pkg;

   // Field widths.
   localparam int NUM_COEFS = 7;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 16;
   localparam int OUT_W     = 24;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int SUM_W     = PROD_W + 3;

   // Results per word at most, and queue depths.
   localparam int MAX_OUT   = 4;
   localparam int JOB_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   // Saturation bounds of the filtered value.
   localparam int SAT_HI = 8388607;
   localparam int SAT_LO = -8388608;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_TAP_COUNT = 3'd0;
   localparam logic [2:0] CSR_COEF_0    = 3'd1;
   localparam logic [2:0] CSR_COEF_6    = 3'd7;

   // Value of the first coefficient after reset: a gain of one in Q4.12.
   localparam logic [COEF_W-1:0] COEF_0_RESET = 16'd4096;

   typedef logic [NUM_COEFS-1:0][COEF_W-1:0]   coef_set_type;
   typedef logic [NUM_COEFS-1:0][SAMPLE_W-1:0] win_set_type;

   // One classified input word: the window after it and the results it releases.
   typedef struct packed {
      win_set_type win;
      logic [1:0]  first_dist;
      logic [2:0]  count;
      logic        last;
   } job_type;

   typedef struct packed {
      logic [OUT_W-1:0] filtered;
      logic             clipped;
      logic             line_done;
   } rsp_type;

endpackage

[hdl/line_convolution_zero_pad.sv]
// Top level of the zero-padded line convolution filter.
//
// Samples of an image line enter through a queue-like port: a word is taken
// at a clock edge with push high and full low. Results leave the same way:
// while empty is low the oldest result sits on the rsp_ ports and is taken
// with pop. Configuration (tap count, seven Q4.12 coefficients) is written
// through its own valid/ready port, which is always ready; write it only
// while the block is idle.
// The first result released by a sample passes the word queue, the product
// and sum registers and the result queue before it shows on the rsp_ ports.
// Throughput: one sample and one result per cycle while no queue is full; the
// three-stage multiply-accumulate pipeline issues one result a cycle, so the
// final sample of a line, which releases up to four results, holds the
// pipeline while the four-entry word queue absorbs input.
// Reset clears the window, counts and queues, and loads one tap of gain one.
// When the receiver stalls, the four-entry result queue fills, the pipeline
// stops issuing, the word queue fills, and full rises; nothing is dropped.
`include "assert_macros.svh"

module line_convolution_zero_pad #(
   parameter int MAX_TAPS       = 7,
   parameter int MAX_LINE       = 4096,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic signed [lcz_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_line_end,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [lcz_pkg::OUT_W-1:0]    rsp_filtered,
   output logic                                rsp_clipped,
   output logic                                rsp_line_done,
   input  logic                                valid,
   output logic                                ready,
   input  logic [2:0]                          csr_index,
   input  logic [lcz_pkg::COEF_W-1:0]          csr_data
);

   localparam int TAP_LIMIT = (MAX_TAPS < lcz_pkg::NUM_COEFS) ? MAX_TAPS : lcz_pkg::NUM_COEFS;
   localparam lcz_pkg::coef_set_type COEF_RESET =
      {{((lcz_pkg::NUM_COEFS - 1) * lcz_pkg::COEF_W){1'b0}}, lcz_pkg::COEF_0_RESET};

   logic [2:0]            tap_count_ff, tap_count_in;
   lcz_pkg::coef_set_type coef_ff, coef_in;
   logic [2:0]            taps_act;
   logic [2:0]            coef_sel;
   logic                  accept, job_push, job_full, job_empty, job_pop;
   lcz_pkg::job_type      job_wr, job_rd;
   lcz_pkg::rsp_type      rsp;

   // Configuration registers.
   assign ready    = 1'b1;
   assign coef_sel = csr_index - lcz_pkg::CSR_COEF_0;

   always_comb begin
      tap_count_in = tap_count_ff;
      coef_in      = coef_ff;
      if (valid) begin
         case (csr_index) inside
            lcz_pkg::CSR_TAP_COUNT: begin
               tap_count_in = csr_data[2:0];
            end
            [lcz_pkg::CSR_COEF_0:lcz_pkg::CSR_COEF_6]: begin
               coef_in[coef_sel] = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= 3'd1;
         coef_ff      <= COEF_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
         coef_ff      <= coef_in;
      end
   end

   // Taps in use: zero counts as one, and the count is limited by the build.
   always_comb begin
      taps_act = (tap_count_ff == 3'd0) ? 3'd1 : tap_count_ff;
      if (taps_act > 3'(TAP_LIMIT)) begin
         taps_act = 3'(TAP_LIMIT);
      end
   end

   assign full   = job_full;
   assign accept = push && !job_full;

   lcz_front #(
      .MAX_TAPS (MAX_TAPS),
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .sample   (req_sample),
      .line_end (req_line_end),
      .taps     (taps_act),
      .job_push (job_push),
      .job      (job_wr)
   );

   lcz_queue #(
      .WIDTH ($bits(lcz_pkg::job_type)),
      .DEPTH (lcz_pkg::JOB_DEPTH)
   ) u_job_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_wr),
      .full    (job_full),
      .rd_en   (job_pop),
      .rd_data (job_rd),
      .empty   (job_empty)
   );

   lcz_back #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_rd),
      .job_pop   (job_pop),
      .coef      (coef_ff),
      .taps      (taps_act),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_filtered  = rsp.filtered;
   assign rsp_clipped   = rsp.clipped;
   assign rsp_line_done = rsp.line_done;

   // A word enters the queue only when it was taken, so the queue has room.
   `ASSERT_IMPLIES(a_job_room, job_push, !job_full, "word pushed into a full queue")
   // A word releases at least one result and never reaches past its newest sample.
   `ASSERT_IMPLIES(a_job_shape, job_push,
      (job_wr.count != 3'd0) && (({1'b0, job_wr.first_dist} + 3'd1) >= job_wr.count),
      "word released results outside the window")
   // The tap count in use stays within what the build supports.
   `ASSERT_ALWAYS(a_taps_range, (taps_act != 3'd0) && (taps_act <= 3'(TAP_LIMIT)),
      "tap count in use out of range")

endmodule

[hdl/lcz_queue.sv]
// Small first-in first-out queue built from registers.
module lcz_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hdl/lcz_front.sv]
// Front end: takes samples, keeps the window and line counts, and classifies each word.
module lcz_front #(
   parameter int MAX_TAPS = 7,
   parameter int MAX_LINE = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic signed [lcz_pkg::SAMPLE_W-1:0]  sample,
   input  logic                                 line_end,
   input  logic [2:0]                           taps,
   output logic                                 job_push,
   output lcz_pkg::job_type                     job
);

   localparam int WIN_DEPTH = (MAX_TAPS < lcz_pkg::NUM_COEFS) ? MAX_TAPS : lcz_pkg::NUM_COEFS;
   localparam int CNT_W     = $clog2(MAX_LINE);

   logic [lcz_pkg::SAMPLE_W-1:0] win_ff [WIN_DEPTH];
   logic [lcz_pkg::SAMPLE_W-1:0] win_in [WIN_DEPTH];
   logic [lcz_pkg::SAMPLE_W-1:0] win_shift [WIN_DEPTH];
   logic [CNT_W-1:0]             recv_ff, recv_in;
   logic [CNT_W:0]               recv_next;
   logic [1:0]                   pend_ff, pend_in;
   logic [2:0]                   pend_new, right, count;
   logic                         last;

   // Window after the new sample shifts in, newest first.
   always_comb begin
      win_shift[0] = sample;
      for (int i = 1; i < WIN_DEPTH; i++) begin
         win_shift[i] = win_ff[i-1];
      end
   end

   // Results released by this word: the pending positions up to the emit point.
   always_comb begin
      recv_next = {1'b0, recv_ff} + 1'b1;
      last      = line_end || (recv_next == (CNT_W+1)'(MAX_LINE));
      pend_new  = {1'b0, pend_ff} + 3'd1;
      right     = taps - 3'd1 - (taps >> 1);
      if (last) begin
         count = pend_new;
      end else if (pend_new > right) begin
         count = pend_new - right;
      end else begin
         count = 3'd0;
      end
      if (count > 3'(lcz_pkg::MAX_OUT)) begin
         count = 3'(lcz_pkg::MAX_OUT);
      end
   end

   // Window snapshot travels with the word; taps past the window read zero.
   for (genvar g = 0; g < lcz_pkg::NUM_COEFS; g++) begin : g_snap
      if (g < WIN_DEPTH) begin : g_held
         assign job.win[g] = win_shift[g];
      end else begin : g_zero
         assign job.win[g] = '0;
      end
   end

   assign job.first_dist = 2'(pend_new - 3'd1);
   assign job.count      = count;
   assign job.last       = last;
   assign job_push       = accept && (count != 3'd0);

   // Next state; the end of a line clears window and counts.
   always_comb begin
      win_in  = win_ff;
      recv_in = recv_ff;
      pend_in = pend_ff;
      if (accept) begin
         if (last) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
               win_in[i] = '0;
            end
            recv_in = '0;
            pend_in = '0;
         end else begin
            win_in  = win_shift;
            recv_in = recv_next[CNT_W-1:0];
            pend_in = 2'(pend_new - count);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
         recv_ff <= '0;
         pend_ff <= '0;
      end else begin
         win_ff  <= win_in;
         recv_ff <= recv_in;
         pend_ff <= pend_in;
      end
   end

endmodule

[hdl/lcz_back.sv]
// Back end: expands each classified word into results through a three-stage MAC pipeline.
module lcz_back #(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_empty,
   input  lcz_pkg::job_type      job,
   output logic                  job_pop,
   input  lcz_pkg::coef_set_type coef,
   input  logic [2:0]            taps,
   output logic                  empty,
   input  logic                  pop,
   output lcz_pkg::rsp_type      rsp
);

   localparam int SUM_W = lcz_pkg::SUM_W;
   localparam int OCC_W = $clog2(lcz_pkg::OUT_DEPTH + 1);
   localparam logic signed [SUM_W-1:0] RND =
      SUM_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

   logic [1:0]                            idx_ff, idx_in;
   logic [OCC_W-1:0]                      occ_ff, occ_in;
   logic                                  issue, final_res, out_full, do_pop;
   logic [1:0]                            lag, half;
   logic signed [4:0]                     k [lcz_pkg::NUM_COEFS];
   logic signed [lcz_pkg::PROD_W-1:0]     prod_in [lcz_pkg::NUM_COEFS];
   logic signed [lcz_pkg::PROD_W-1:0]     prod_ff [lcz_pkg::NUM_COEFS];
   logic                                  v1_ff, v2_ff;
   logic                                  done1_ff, done2_ff;
   logic signed [SUM_W-1:0]               sum_in, sum_ff, adj, q;
   lcz_pkg::rsp_type                      res;

   // Issue one result a cycle while the result queue has a slot reserved for it.
   assign do_pop    = pop && !empty;
   assign issue     = !job_empty && (occ_ff < OCC_W'(lcz_pkg::OUT_DEPTH));
   assign final_res = ({1'b0, idx_ff} == (job.count - 3'd1));
   assign job_pop   = issue && final_res;
   assign lag       = job.first_dist - idx_ff;
   assign half      = 2'(taps >> 1);

   always_comb begin
      idx_in = idx_ff;
      if (issue) begin
         idx_in = final_res ? 2'd0 : idx_ff + 2'd1;
      end
      occ_in = occ_ff;
      if (issue && !do_pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (do_pop && !issue) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   // Stage one: every tap picks its sample from the snapshot and multiplies.
   always_comb begin
      for (int j = 0; j < lcz_pkg::NUM_COEFS; j++) begin
         k[j]       = 5'(lag) + 5'(half) - 5'(j);
         prod_in[j] = '0;
         if ((j < int'(taps)) && !k[j][4] && (k[j] < 5'(lcz_pkg::NUM_COEFS))) begin
            prod_in[j] = $signed(coef[j]) * $signed(job.win[k[j][2:0]]);
         end
      end
   end

   // Stage two: add the products.
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < lcz_pkg::NUM_COEFS; j++) begin
         sum_in = sum_in + SUM_W'(prod_ff[j]);
      end
   end

   // Stage three: shift with truncation toward zero, then saturate.
   always_comb begin
      adj = sum_ff + (sum_ff[SUM_W-1] ? RND : '0);
      q   = adj >>> COEF_FRAC_BITS;
      res.clipped   = 1'b0;
      res.line_done = done2_ff;
      res.filtered  = q[lcz_pkg::OUT_W-1:0];
      if (q > SUM_W'(lcz_pkg::SAT_HI)) begin
         res.filtered = lcz_pkg::OUT_W'(lcz_pkg::SAT_HI);
         res.clipped  = 1'b1;
      end else if (q < SUM_W'(lcz_pkg::SAT_LO)) begin
         res.filtered = lcz_pkg::OUT_W'(lcz_pkg::SAT_LO);
         res.clipped  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         occ_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         occ_ff <= occ_in;
         v1_ff  <= issue;
         v2_ff  <= v1_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      done1_ff <= final_res && job.last;
      sum_ff   <= sum_in;
      done2_ff <= done1_ff;
   end

   // Result queue; reserved slots keep it from overflowing.
   lcz_queue #(
      .WIDTH ($bits(lcz_pkg::rsp_type)),
      .DEPTH (lcz_pkg::OUT_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (v2_ff),
      .wr_data (res),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (rsp),
      .empty   (empty)
   );

   logic unused_full;
   assign unused_full = out_full;

endmodule
